### hdl/clipped_line_pixel_stepper_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line pixel stepper
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH
`define CLIPPED_LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define CLPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/clps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_pkg
// Shared constants, codes and types of the line pixel stepper.
// ----------------------------------------------------------------------------
package clps_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int CFG_BITS       = 14;
	localparam int OFF_BITS       = 30;
	localparam int CHAN_BITS      = 8;
	localparam int COLOR_BITS     = 3 * CHAN_BITS;
	localparam int REG_IDX_BITS   = 1;

	localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(640);
	localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(480);

	localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic load;
		logic tick;
	} step_cmd_t;

	typedef struct packed {
		logic active;
		logic done;
	} step_stat_t;

endpackage

### hdl/clipped_line_pixel_stepper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_pixel_stepper_unit
// All-octant Bresenham line stepper with clipping to a bottom-up 24-bit image.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 loads endpoints and colour and
// gives no result; kind 1 emits the current pixel and steps once, or ends the
// line at its end pixel. A tick with no line in progress gives no result.
// Output channel (out_valid / out_stall): one transaction per emitted pixel,
// with the clip flag, BMP byte offset, coordinates, colour and end flag.
// Config channel (cfg_valid / cfg_ready): always ready; index 0 is the image
// width, index 1 the image height. Write only while the block is idle.
// An accepted tick's pixel is registered in the clip stage, then the offset stage.
// Throughput: one item per cycle unless in_stall is high; the stepper state
// updates in the accepting cycle; the offset multiplier has its own stage.
// When the receiver stalls, the two pixel stages fill and in_stall rises; the
// pipeline holds without loss. Reset clears the line state, empties the
// pipeline and sets the image to 640 x 480.
// ----------------------------------------------------------------------------
module clipped_line_pixel_stepper_unit import clps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [COORD_BITS-1:0]   x_start,
	input  logic [COORD_BITS-1:0]   y_start,
	input  logic [COORD_BITS-1:0]   x_end,
	input  logic [COORD_BITS-1:0]   y_end,
	input  logic [CHAN_BITS-1:0]    blue_in,
	input  logic [CHAN_BITS-1:0]    green_in,
	input  logic [CHAN_BITS-1:0]    red_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    write_valid,
	output logic [OFF_BITS-1:0]     byte_offset,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic [CHAN_BITS-1:0]    blue_out,
	output logic [CHAN_BITS-1:0]    green_out,
	output logic [CHAN_BITS-1:0]    red_out,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	`include "clipped_line_pixel_stepper_unit_assert.svh"

	logic [CFG_BITS-1:0]   img_w_q, img_h_q;
	logic                  in_acc, emit;
	step_cmd_t             cmd;
	step_stat_t            stat;
	logic [COORD_BITS-1:0] cur_x, cur_y;
	logic [COLOR_BITS-1:0] color, pix_color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= WIDTH_RST;
			img_h_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  img_w_q <= cfg_data;
				REG_HEIGHT: img_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign cmd.load = in_acc && (kind == KIND_LOAD);
	assign cmd.tick = in_acc && (kind == KIND_TICK);
	assign emit     = cmd.tick && stat.active;

	clps_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.color_in ({red_in, green_in, blue_in}),
		.stat     (stat),
		.cur_x    (cur_x),
		.cur_y    (cur_y),
		.color    (color)
	);

	clps_pix #(
		.COORD_BITS(COORD_BITS)
	) u_pix (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.stat        (stat),
		.cur_x       (cur_x),
		.cur_y       (cur_y),
		.color       (color),
		.img_w       (img_w_q),
		.img_h       (img_h_q),
		.hold        (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_valid (write_valid),
		.byte_offset (byte_offset),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pix_color),
		.last        (last)
	);

	assign blue_out  = pix_color[CHAN_BITS-1:0];
	assign green_out = pix_color[2*CHAN_BITS-1:CHAN_BITS];
	assign red_out   = pix_color[3*CHAN_BITS-1:2*CHAN_BITS];

	`CLPS_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "stall, output free")
	`CLPS_ASSERT_NOW(a_clipped_offset_zero, out_valid && !write_valid, byte_offset == '0, "clip offset")
	`CLPS_ASSERT_NEXT(a_load_activates, cmd.load, stat.active, "line not active after load")
	`CLPS_ASSERT_NEXT(a_end_deactivates, emit && stat.done, !stat.active, "line active after end")

endmodule

### hdl/clps_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_step
// Bresenham stepper state: line setup on load, one step per tick until the end point.
// ----------------------------------------------------------------------------
module clps_step import clps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  step_cmd_t             cmd,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] color_in,
	output step_stat_t            stat,
	output logic [COORD_BITS-1:0] cur_x,
	output logic [COORD_BITS-1:0] cur_y,
	output logic [COLOR_BITS-1:0] color
);

	localparam int EB = COORD_BITS + 2;
	localparam int EW = COORD_BITS + 3;

	logic                         active_q;
	logic [COORD_BITS-1:0]        cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, dx_q;
	logic signed [COORD_BITS:0]   dyn_q;
	logic                         sxn_q, syn_q;
	logic signed [EB-1:0]         err_q;
	logic [COLOR_BITS-1:0]        color_q;

	logic [COORD_BITS-1:0]        dx_ld, dy_ld;
	logic signed [COORD_BITS:0]   dyn_ld;
	logic signed [EB-1:0]         err_ld;
	logic                         done;
	logic signed [EW-1:0]         e2, dx_w, dyn_w, err_w;
	logic                         mv_x, mv_y;

	always_comb begin
		dx_ld  = (x_end > x_start) ? x_end - x_start : x_start - x_end;
		dy_ld  = (y_end > y_start) ? y_end - y_start : y_start - y_end;
		dyn_ld = -$signed({1'b0, dy_ld});
		err_ld = $signed({2'b00, dx_ld}) + $signed({dyn_ld[COORD_BITS], dyn_ld});
	end

	always_comb begin
		done  = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
		e2    = $signed({err_q, 1'b0});
		dx_w  = $signed({3'b000, dx_q});
		dyn_w = $signed({{2{dyn_q[COORD_BITS]}}, dyn_q});
		mv_x  = e2 >= dyn_w;
		mv_y  = e2 <= dx_w;
		err_w = $signed({err_q[EB-1], err_q});
		if (mv_x) begin
			err_w = err_w + dyn_w;
		end
		if (mv_y) begin
			err_w = err_w + dx_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dyn_q    <= '0;
			sxn_q    <= 1'b0;
			syn_q    <= 1'b0;
			err_q    <= '0;
			color_q  <= '0;
		end else if (cmd.load) begin
			active_q <= 1'b1;
			cur_x_q  <= x_start;
			cur_y_q  <= y_start;
			tgt_x_q  <= x_end;
			tgt_y_q  <= y_end;
			dx_q     <= dx_ld;
			dyn_q    <= dyn_ld;
			sxn_q    <= !(x_start < x_end);
			syn_q    <= !(y_start < y_end);
			err_q    <= err_ld;
			color_q  <= color_in;
		end else if (cmd.tick && active_q) begin
			if (done) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_w[EB-1:0];
				if (mv_x) begin
					cur_x_q <= sxn_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
				end
				if (mv_y) begin
					cur_y_q <= syn_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
				end
			end
		end
	end

	assign stat.active = active_q;
	assign stat.done   = done;
	assign cur_x       = cur_x_q;
	assign cur_y       = cur_y_q;
	assign color       = color_q;

endmodule

### hdl/clps_pix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_pix
// Two-stage pixel pipeline: clip and row setup, then byte offset and output.
// ----------------------------------------------------------------------------
module clps_pix import clps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  emit,
	input  step_stat_t            stat,
	input  logic [COORD_BITS-1:0] cur_x,
	input  logic [COORD_BITS-1:0] cur_y,
	input  logic [COLOR_BITS-1:0] color,
	input  logic [CFG_BITS-1:0]   img_w,
	input  logic [CFG_BITS-1:0]   img_h,
	output logic                  hold,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  write_valid,
	output logic [OFF_BITS-1:0]   byte_offset,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last
);

	localparam int WB   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
	localparam int RB   = CFG_BITS + 2;
	localparam int XB   = COORD_BITS + 2;
	localparam int PB   = CFG_BITS + RB;
	localparam int SB   = ((PB > XB) ? PB : XB) + 1;

	logic                  s1_valid_q, s2_valid_q;
	logic                  s1_en, s2_en;

	logic                  in_img;
	logic [WB-1:0]         row_w;
	logic [RB-1:0]         rb_w;

	logic                  in_s1, last_s1;
	logic [CFG_BITS-1:0]   row_s1;
	logic [RB-1:0]         rb_s1;
	logic [XB-1:0]         x3_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [COLOR_BITS-1:0] col_s1;

	logic [PB-1:0]         prod;
	logic [SB-1:0]         sum;

	logic                  wv_s2, last_s2;
	logic [OFF_BITS-1:0]   off_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [COLOR_BITS-1:0] col_s2;

	assign s2_en = !s2_valid_q || !out_stall;
	assign s1_en = !s1_valid_q || s2_en;
	assign hold  = !s1_en;

	always_comb begin
		in_img = (WB'(cur_x) < WB'(img_w)) && (WB'(cur_y) < WB'(img_h));
		row_w  = WB'(img_h) - WB'(cur_y) - WB'(1);
		rb_w   = (RB'({img_w, 1'b0}) + RB'(img_w) + RB'(3)) & ~RB'(3);
	end

	always_ff @(posedge clk) begin
		if (s1_en && emit) begin
			in_s1   <= in_img;
			last_s1 <= stat.done;
			row_s1  <= in_img ? row_w[CFG_BITS-1:0] : '0;
			rb_s1   <= rb_w;
			x3_s1   <= in_img ? XB'({cur_x, 1'b0}) + XB'(cur_x) : '0;
			x_s1    <= cur_x;
			y_s1    <= cur_y;
			col_s1  <= color;
		end
	end

	assign prod = PB'(row_s1) * PB'(rb_s1);
	assign sum  = SB'(prod) + SB'(x3_s1);

	always_ff @(posedge clk) begin
		if (s2_en && s1_valid_q) begin
			wv_s2   <= in_s1;
			last_s2 <= last_s1;
			off_s2  <= sum[OFF_BITS-1:0];
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			col_s2  <= col_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_valid_q <= emit;
			end
			if (s2_en) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	assign out_valid   = s2_valid_q;
	assign write_valid = wv_s2;
	assign byte_offset = off_s2;
	assign pixel_x     = x_s2;
	assign pixel_y     = y_s2;
	assign pixel_color = col_s2;
	assign last        = last_s2;

endmodule
